[src/deq_pkg.sv]
// Shared types, sizes and operation codes for the double-ended queue.
// No dependencies; every other file but deq_ram imports this package.
`default_nettype none
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [1:0]              kind_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam kind_t KIND_PUSH_FRONT = 2'd0;
  localparam kind_t KIND_PUSH_BACK  = 2'd1;
  localparam kind_t KIND_POP_FRONT  = 2'd2;
  localparam kind_t KIND_POP_BACK   = 2'd3;

  // Store access issued by the controller.
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr_front;
    idx_t  raddr_back;
  } mem_req_t;

  // Completion status handed to the output stage.
  typedef struct packed {
    logic load;
    logic rejected;
    cnt_t count;
  } done_t;

endpackage
`default_nettype wire

[src/deq_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on deq_pkg for payload types.
`default_nettype none
interface deq_in_if import deq_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  data_t push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t front_value;
  data_t back_value;
  cnt_t  item_count;
  logic  is_empty;
  logic  push_rejected;

  modport source (output valid, output front_value, output back_value, output item_count,
                  output is_empty, output push_rejected, input ready);
  modport sink   (input valid, input front_value, input back_value, input item_count,
                  input is_empty, input push_rejected, output ready);
endinterface
`default_nettype wire

[src/deq_ram.sv]
// Generic store: one write port, two read ports, registered read data.
// Standalone; no package needed.
`default_nettype none
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

[src/deq_ctrl.sv]
// Pointer state and sequencer: update, write, then read both ends.
// Depends on deq_pkg.
`default_nettype none
module deq_ctrl import deq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire kind_t in_kind,
  input  wire data_t in_push_value,
  output logic       in_ready,
  input  wire logic  out_free,
  output mem_req_t   mem_req,
  output done_t      done
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int SUM_W = IDX_W + 1;

  logic [1:0] state_r, state_nxt;
  idx_t       front_r, front_nxt;
  cnt_t       occ_r, occ_nxt;
  logic       rej_r, rej_nxt;
  logic       accept;
  logic       full;

  function automatic idx_t wrap_add(idx_t base, idx_t off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = (occ_r == CNT_W'(DEPTH));

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    occ_nxt       = occ_r;
    rej_nxt       = rej_r;
    mem_req       = '0;
    mem_req.wdata = in_push_value;
    done          = '0;
    done.rejected = rej_r;
    done.count    = occ_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rej_nxt   = 1'b0;
          state_nxt = ST_READ;
          case (in_kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                rej_nxt = 1'b1;
              end else begin
                front_nxt     = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
                mem_req.we    = 1'b1;
                mem_req.waddr = front_nxt;
                occ_nxt       = occ_r + 1'b1;
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                rej_nxt = 1'b1;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wrap_add(front_r, occ_r[IDX_W-1:0]);
                occ_nxt       = occ_r + 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              if (occ_r != '0) begin
                front_nxt = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
                occ_nxt   = occ_r - 1'b1;
              end
            end
            default: begin
              if (occ_r != '0) begin
                occ_nxt = occ_r - 1'b1;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        // write landed last cycle, so both ends read back current data
        mem_req.re          = (occ_r != '0);
        mem_req.raddr_front = front_r;
        mem_req.raddr_back  = wrap_add(front_r, occ_r[IDX_W-1:0] - 1'b1);
        state_nxt           = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          done.load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      occ_r   <= '0;
      rej_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      rej_r   <= rej_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= IDX_W'(DEPTH - 1))
    else $error("front index beyond depth");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_PUSH_FRONT || in_kind == KIND_PUSH_BACK) && full
    |=> rej_r && occ_r == CNT_W'(DEPTH))
    else $error("push while full not rejected");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ)
    else $error("request not followed by store read");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> accept)
    else $error("store write outside an accepted request");

endmodule
`default_nettype wire

[src/double_ended_queue_core.sv]
// Each request runs in order: write the slot store, read both ends, then load the output
// register; a stalled result holds the controller in its last step. A new request is taken
// only once the controller has loaded the last result and is idle again.
// The next request is taken while a finished result waits in the output register.
// Reset (rst_n low, synchronous): deque empty, front index zero, no result pending.
// Files: deq_pkg, deq_if, deq_ram, deq_ctrl.
`default_nettype none
module double_ended_queue_core import deq_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  deq_in_if.sink   in_req,
  deq_out_if.source out_res
);

  mem_req_t mem_req;
  done_t    done;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;
  data_t    rd_front, rd_back;
  data_t    front_r, back_r;
  cnt_t     count_r;
  logic     empty_r, rej_r;
  logic     is_empty;

  // Output stage can take a new result when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_res.ready;

  deq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_req.valid),
    .in_kind       (in_req.kind),
    .in_push_value (in_req.push_value),
    .in_ready      (in_req.ready),
    .out_free      (out_free),
    .mem_req       (mem_req),
    .done          (done)
  );

  // Slot store; only occupied slots are ever read, so no clearing is needed.
  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .re      (mem_req.re),
    .raddr_a (mem_req.raddr_front),
    .raddr_b (mem_req.raddr_back),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  assign is_empty = (done.count == '0);

  // Hold the result until taken; advance on a load from the controller.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: empty deque reports -1 at both ends.
  always_ff @(posedge clk) begin
    if (done.load) begin
      front_r <= is_empty ? '1 : rd_front;
      back_r  <= is_empty ? '1 : rd_back;
      count_r <= done.count;
      empty_r <= is_empty;
      rej_r   <= done.rejected;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.front_value   = front_r;
  assign out_res.back_value    = back_r;
  assign out_res.item_count    = count_r;
  assign out_res.is_empty      = empty_r;
  assign out_res.push_rejected = rej_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done.load |-> out_free)
    else $error("result loaded over a pending one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res.ready |=> out_valid_r && $stable(count_r))
    else $error("stalled result lost");

  a_empty_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && empty_r |-> front_r == '1 && back_r == '1 && count_r == '0)
    else $error("empty result malformed");

endmodule
`default_nettype wire

[bench/tb_double_ended_queue_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_core: drives push/pop requests and
// checks every status result against a local deque model. Depends on deq_pkg and deq_if.
module tb_double_ended_queue_core;
  import deq_pkg::*;

  localparam int LATENCY = 2;

  // One status record per request, in the order the block returns them.
  typedef struct packed {
    data_t front_value;
    data_t back_value;
    cnt_t  item_count;
    logic  is_empty;
    logic  push_rejected;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_req();
  deq_out_if out_res();

  double_ended_queue_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res)
  );

  // 20 ns period: high and low halves of 10 ns each.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the deque: slot store, front position and fill level.
  data_t   model_slots [DEPTH];
  int      model_front;
  int      model_count;
  status_t pending_status_q [$];

  // Idling controls shared between the test tasks and the driver processes.
  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold_cycles;

  // Run statistics for the summary.
  int mismatch_count;
  int error_count;
  int checked_count;
  int push_count;
  int pop_count;
  int reject_count;
  int empty_pop_count;
  int full_hits;

  // Apply one request to the local deque and return the status it must produce.
  function automatic status_t step_deque_model(kind_t kind, data_t value);
    status_t st;
    st = '0;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (model_count >= DEPTH) begin
          st.push_rejected = 1'b1;
        end else begin
          model_front = (model_front + DEPTH - 1) % DEPTH;
          model_slots[model_front] = value;
          model_count++;
        end
      end
      KIND_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          st.push_rejected = 1'b1;
        end else begin
          model_slots[(model_front + model_count) % DEPTH] = value;
          model_count++;
        end
      end
      KIND_POP_FRONT: begin
        if (model_count != 0) begin
          model_front = (model_front + 1) % DEPTH;
          model_count--;
        end
      end
      default: begin
        if (model_count != 0) begin
          model_count--;
        end
      end
    endcase
    // An empty deque reports -1 at both ends.
    if (model_count == 0) begin
      st.front_value = -1;
      st.back_value  = -1;
      st.is_empty    = 1'b1;
    end else begin
      st.front_value = model_slots[model_front];
      st.back_value  = model_slots[(model_front + model_count - 1) % DEPTH];
      st.is_empty    = 1'b0;
    end
    st.item_count = cnt_t'(model_count);
    return st;
  endfunction

  // Offer one request, optionally after a random idle burst, and hold it until taken.
  task automatic send_request(input kind_t kind, input data_t value);
    int gap;
    bit was_empty;
    status_t st_exp;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_req.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_req.valid      <= 1'b1;
    in_req.kind       <= kind;
    in_req.push_value <= value;
    do @(posedge clk); while (!in_req.ready);
    // Request taken at this edge: record what it must produce.
    was_empty = (model_count == 0);
    st_exp = step_deque_model(kind, value);
    pending_status_q = {pending_status_q, st_exp};
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
      push_count++;
      if (st_exp.push_rejected) reject_count++;
    end else begin
      pop_count++;
      if (was_empty) empty_pop_count++;
    end
    if (model_count == DEPTH) full_hits++;
  endtask

  // Drop valid and wait until every outstanding result has been checked.
  task automatic wait_for_drain();
    @(negedge clk);
    in_req.valid <= 1'b0;
    wait (pending_status_q.size() == 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Mostly random values, with the signed extremes thrown in often.
  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -1;
      3:       return 0;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Empty pops, extremes at both ends, and the last element leaving from each end.
  task automatic test_directed_edges();
    send_request(KIND_POP_FRONT, 32'sh1234_5678);
    send_request(KIND_POP_BACK, 32'shDEAD_BEEF);
    send_request(KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(KIND_POP_BACK, 32'sh0);
    send_request(KIND_PUSH_BACK, 32'sh8000_0000);
    send_request(KIND_POP_FRONT, -1);
    send_request(KIND_PUSH_FRONT, 32'sh0);
    send_request(KIND_PUSH_BACK, -1);
    send_request(KIND_PUSH_FRONT, 32'shAAAA_5555);
    send_request(KIND_PUSH_BACK, 32'sh5555_AAAA);
    send_request(KIND_POP_FRONT, 32'sh0);
    send_request(KIND_POP_BACK, 32'sh0);
    send_request(KIND_POP_BACK, 32'sh0);
    send_request(KIND_POP_FRONT, 32'sh0);
    send_request(KIND_POP_FRONT, 32'sh0);
  endtask

  // Fill to capacity from both ends, push into a full deque, then drain past empty.
  task automatic test_fill_and_overflow();
    int i;
    for (i = 0; i < DEPTH; i++) begin
      send_request((i % 2 == 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_value());
    end
    send_request(KIND_PUSH_FRONT, pick_value());
    send_request(KIND_PUSH_BACK, pick_value());
    for (i = 0; i < DEPTH + 2; i++) begin
      send_request((i % 2 == 0) ? KIND_POP_FRONT : KIND_POP_BACK, pick_value());
    end
  endtask

  // Random operations; the push share shifts in phases so the deque swings
  // between empty and full and the indices wrap many times.
  task automatic test_random_mix(input int n_items);
    int i;
    int push_pct;
    kind_t kind;
    push_pct = 50;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 20;
          1:       push_pct = 80;
          2:       push_pct = 95;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(1, 100) <= push_pct) begin
        kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      end else begin
        kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end
      send_request(kind, pick_value());
    end
  endtask

  // Hold the result side for a long stretch while requests keep coming,
  // so the block backs up and stalls its input.
  task automatic test_result_backpressure();
    sink_hold_cycles = 300;
    test_random_mix(40);
  endtask

  // Result checker: compare each returned status with the oldest expectation.
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got.front_value   = out_res.front_value;
      got.back_value    = out_res.back_value;
      got.item_count    = out_res.item_count;
      got.is_empty      = out_res.is_empty;
      got.push_rejected = out_res.push_rejected;
      if (pending_status_q.size() == 0) begin
        error_count++;
        $display("ERROR: unexpected result front=%0d back=%0d count=%0d",
                 got.front_value, got.back_value, got.item_count);
      end else begin
        want = pending_status_q[0];
        pending_status_q.delete(0);
        checked_count++;
        if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
            got.item_count !== want.item_count || got.is_empty !== want.is_empty ||
            got.push_rejected !== want.push_rejected) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("MISMATCH #%0d at result %0d:", mismatch_count, checked_count);
            $display("  expected front=%0d back=%0d count=%0d empty=%0b rejected=%0b",
                     want.front_value, want.back_value, want.item_count,
                     want.is_empty, want.push_rejected);
            $display("  actual   front=%0d back=%0d count=%0d empty=%0b rejected=%0b",
                     got.front_value, got.back_value, got.item_count,
                     got.is_empty, got.push_rejected);
          end
        end
      end
    end
  end

  // Result-side ready: random stall bursts, plus a long hold when a test asks.
  initial begin
    int gap;
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_res.ready <= 1'b0;
        repeat (sink_hold_cycles - 1) @(negedge clk);
        sink_hold_cycles = 0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_res.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // Safety net: end the run if the block hangs.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    // Drive every input to a known value before reset releases.
    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.kind       = KIND_PUSH_FRONT;
    in_req.push_value = '0;
    model_front       = 0;
    model_count       = 0;
    src_idle_en       = 1'b1;
    sink_idle_en      = 1'b1;
    sink_hold_cycles  = 0;

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_fill_and_overflow();
    // Pause the sender until every result is back before moving on.
    wait_for_drain();
    test_random_mix(800);
    test_result_backpressure();
    wait_for_drain();

    // Last stretch runs at full rate on both sides.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_mix(150);
    wait_for_drain();

    $display("Covered %0d pushes (%0d refused on a full deque) and %0d pops (%0d on empty).",
             push_count, reject_count, pop_count, empty_pop_count);
    $display("Checked %0d results, deque reached capacity %0d times, %0d mismatches.",
             checked_count, full_hits, mismatch_count);
    if (mismatch_count == 0 && error_count == 0 && pending_status_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
